// File: rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types, widths and helpers of the line rasterizer core.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

  localparam int COORD_BITS  = 11;
  localparam int COLOR_BITS  = 24;
  // twice an absolute delta
  localparam int DELTA2_BITS = COORD_BITS + 1;
  // decision term stays within +/- twice the largest delta
  localparam int ERR_BITS    = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [COLOR_BITS-1:0]  color_t;
  typedef logic [DELTA2_BITS-1:0] delta2_t;
  typedef logic [ERR_BITS-1:0]    err_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last;
    logic   valid_res;
  } out_item_t;

  typedef struct packed {
    coord_t  major_pos;
    coord_t  minor_pos;
    coord_t  major_remaining;
    err_t    error_term;
    delta2_t twice_minor_delta;
    delta2_t twice_major_delta;
    logic    major_step_negative;
    logic    minor_step_negative;
    logic    axes_swapped;
    logic    line_active;
    color_t  held_color;
  } line_state_t;

  function automatic out_item_t emit_pixel(line_state_t st, logic is_last);
    out_item_t o;
    o.pixel_x     = st.axes_swapped ? st.minor_pos : st.major_pos;
    o.pixel_y     = st.axes_swapped ? st.major_pos : st.minor_pos;
    o.pixel_color = st.held_color;
    o.last        = is_last;
    o.valid_res   = 1'b1;
    return o;
  endfunction

endpackage

`default_nettype wire

// File: rtl/blr_setup.sv
// ----------------------------------------------------------------------------
// blr_setup
// Line setup: deltas, octant, major axis choice and initial decision term.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_setup (
  input  blr_pkg::in_item_t    item,
  output blr_pkg::line_state_t st_nxt,
  output blr_pkg::out_item_t   res
);
  import blr_pkg::*;

  logic [COORD_BITS:0] dx;
  logic [COORD_BITS:0] dy;
  logic                xneg;
  logic                yneg;
  coord_t              adx;
  coord_t              ady;
  logic                swap;
  coord_t              dmaj;
  coord_t              dmin;

  always_comb begin
    dx   = {1'b0, item.end_x} - {1'b0, item.start_x};
    dy   = {1'b0, item.end_y} - {1'b0, item.start_y};
    xneg = dx[COORD_BITS];
    yneg = dy[COORD_BITS];
    adx  = xneg ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady  = yneg ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    // y is major on equal deltas
    swap = (ady >= adx);
    dmaj = swap ? ady : adx;
    dmin = swap ? adx : ady;

    st_nxt.axes_swapped        = swap;
    st_nxt.major_pos           = swap ? item.start_y : item.start_x;
    st_nxt.minor_pos           = swap ? item.start_x : item.start_y;
    st_nxt.major_step_negative = swap ? yneg : xneg;
    st_nxt.minor_step_negative = swap ? xneg : yneg;
    st_nxt.twice_major_delta   = {dmaj, 1'b0};
    st_nxt.twice_minor_delta   = {dmin, 1'b0};
    st_nxt.error_term          = {1'b0, dmin, 1'b0} - {2'b00, dmaj};
    st_nxt.major_remaining     = dmaj;
    st_nxt.line_active         = (dmaj != '0);
    st_nxt.held_color          = item.line_color;

    res = emit_pixel(st_nxt, dmaj == '0);
  end

endmodule

`default_nettype wire

// File: rtl/blr_stepper.sv
// ----------------------------------------------------------------------------
// blr_stepper
// One Bresenham step: advance major axis, decide minor move, update error.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_stepper (
  input  blr_pkg::line_state_t st,
  output blr_pkg::line_state_t st_nxt,
  output blr_pkg::out_item_t   res
);
  import blr_pkg::*;

  logic                move_minor;
  logic [ERR_BITS:0]   err_sum;
  logic [ERR_BITS:0]   sub_term;

  always_comb begin
    st_nxt     = st;
    res        = '0;
    // strictly positive decision term
    move_minor = !st.error_term[ERR_BITS-1] && (st.error_term != '0);
    sub_term   = move_minor ? {2'b00, st.twice_major_delta} : '0;
    err_sum    = {st.error_term[ERR_BITS-1], st.error_term}
               + {2'b00, st.twice_minor_delta} - sub_term;

    if (st.line_active) begin
      st_nxt.major_pos = st.major_step_negative ? st.major_pos - 1'b1
                                                : st.major_pos + 1'b1;
      if (move_minor) begin
        st_nxt.minor_pos = st.minor_step_negative ? st.minor_pos - 1'b1
                                                  : st.minor_pos + 1'b1;
      end
      st_nxt.error_term      = err_sum[ERR_BITS-1:0];
      st_nxt.major_remaining = st.major_remaining - 1'b1;
      st_nxt.line_active     = (st.major_remaining != COORD_BITS'(1));
      res = emit_pixel(st_nxt, st.major_remaining == COORD_BITS'(1));
    end
  end

endmodule

`default_nettype wire

// File: rtl/bresenham_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core
// Integer line rasterizer, all octants, one pixel item per clock while out_stall stays low.
// ----------------------------------------------------------------------------
// Takes one item per clock while out_stall stays low and returns one result
// item for each. A load item (cmd = load) starts a line and returns its start
// pixel; each step item returns the next pixel, with last set on the end
// point, or a result with valid_res low when no line is active. An item is
// captured in an input register, passes the setup or step logic (one add and
// compare on the registered decision term) and then lands in the result
// register when that register is free or being drained; the sustained rate is
// one item per clock while out_stall stays low. The line state is updated in
// the same cycle the result register loads, so back-to-back steps chain with
// no gap.
`default_nettype none

module bresenham_line_rasterizer_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  blr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output blr_pkg::out_item_t out_data
);
  import blr_pkg::*;

  in_item_t    in_reg_r;
  logic        in_reg_v_r;
  line_state_t st_r;
  line_state_t st_nxt;
  out_item_t   out_r;
  logic        out_v_r;

  line_state_t load_st;
  out_item_t   load_res;
  line_state_t step_st;
  out_item_t   step_res;
  out_item_t   res_nxt;
  logic        advance;
  logic        in_accept;

  blr_setup u_setup (
    .item   (in_reg_r),
    .st_nxt (load_st),
    .res    (load_res)
  );

  blr_stepper u_stepper (
    .st     (st_r),
    .st_nxt (step_st),
    .res    (step_res)
  );

  always_comb begin
    unique case (in_reg_r.cmd)
      CMD_LOAD: begin
        st_nxt  = load_st;
        res_nxt = load_res;
      end
      CMD_STEP: begin
        st_nxt  = step_st;
        res_nxt = step_res;
      end
      default: begin
        st_nxt  = st_r;
        res_nxt = '0;
      end
    endcase
  end

  // item moves on when the result register is free or being drained
  assign advance   = in_reg_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_reg_v_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_reg_v_r <= 1'b0;
      out_v_r    <= 1'b0;
      st_r       <= '0;
    end else begin
      in_reg_v_r <= in_accept || (in_reg_v_r && !advance);
      out_v_r    <= advance || (out_v_r && out_stall);
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_reg_r <= in_data;
    end
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // an active line always has pixels left
  a_active_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.line_active |-> (st_r.major_remaining != '0))
    else $error("active line with no remaining steps");

  // a held end pixel means the line is finished
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.last) |-> !st_r.line_active)
    else $error("line still active after its end pixel");

  // only a load can wake an idle line
  a_idle_needs_load: assert property (@(posedge clk) disable iff (!rst_n)
    (!st_r.line_active && !(advance && in_reg_r.cmd == CMD_LOAD))
      |=> !st_r.line_active)
    else $error("line became active without a load");

  // a pixel-less result only comes from an idle line
  a_empty_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.valid_res) |-> !st_r.line_active)
    else $error("empty result while a line is active");

endmodule

`default_nettype wire
